FILE: rtl/core/tnns_pkg.sv
`default_nettype none

package tnns_pkg;

  // tile geometry
  localparam int unsigned TILE_SIDE   = 16;
  localparam int unsigned SIDE_W      = $clog2(TILE_SIDE + 1);
  localparam int unsigned STORE_DEPTH = TILE_SIDE * TILE_SIDE;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(STORE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOMINATOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd4;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [7:0]  pixel;
  } cmd_t;

  typedef struct packed {
    logic [15:0] numerator;
    logic [15:0] denominator;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  value;
    logic        enable;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/tile_nearest_neighbor_scaler_core.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------------------
// request   | in        | push / full           | operation, rect_*, pixel_value
// result    | out       | empty / pop           | write_address, write_value, write_enable,
//           |           |                       | last_of_tile
// config    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a load is written into the store as it is popped, a tick passes through store read, multiply, bounds check
// a begin runs up to six 32-step divisions on the shared bit-serial divider
// requests wait in a two-entry queue and results in a two-entry queue, so either side
// may stall on its own; full rises only when the request queue holds two requests
// reset is asynchronous, active low, and leaves both queues empty and the tile idle
`default_nettype none

module tile_nearest_neighbor_scaler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [15:0] rect_left_i,
  input  logic [15:0] rect_top_i,
  input  logic [15:0] rect_right_i,
  input  logic [15:0] rect_bottom_i,
  input  logic [7:0]  pixel_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] write_address_o,
  output logic [7:0]  write_value_o,
  output logic        write_enable_o,
  output logic        last_of_tile_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  tnns_pkg::cfg_t cfg_q;
  tnns_pkg::cmd_t cmd;
  tnns_pkg::res_t res;
  logic           cmd_valid;
  logic           cmd_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numerator    <= 16'd1;
      cfg_q.denominator  <= 16'd1;
      cfg_q.frame_width  <= 16'd1;
      cfg_q.frame_height <= 16'd1;
      cfg_q.frame_length <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tnns_pkg::REG_NUMERATOR:    cfg_q.numerator    <= cfg_data_i[15:0];
        tnns_pkg::REG_DENOMINATOR:  cfg_q.denominator  <= cfg_data_i[15:0];
        tnns_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[15:0];
        tnns_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[15:0];
        tnns_pkg::REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front end: accept and classify
  tnns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .operation_i  (operation_i),
    .rect_left_i  (rect_left_i),
    .rect_top_i   (rect_top_i),
    .rect_right_i (rect_right_i),
    .rect_bottom_i(rect_bottom_i),
    .pixel_value_i(pixel_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // back end: setup, store and drain
  tnns_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .cfg_i      (cfg_q),
    .res_pop_i  (pop && !empty),
    .res_empty_o(empty),
    .res_o      (res)
  );

  assign write_address_o = res.address;
  assign write_value_o   = res.value;
  assign write_enable_o  = res.enable;
  assign last_of_tile_o  = res.last;

endmodule

`default_nettype wire

FILE: rtl/core/tnns_ram.sv
`default_nettype none

module tnns_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tnns_div.sv
`default_nettype none

module tnns_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tnns_pkg::div_req_t req_i,
  output tnns_pkg::div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] shifted;
  logic [32:0] diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (!diff[32]) begin
          rem_q <= diff[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= shifted[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/tnns_front.sv
`default_nettype none

module tnns_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     operation_i,
  input  logic [15:0]    rect_left_i,
  input  logic [15:0]    rect_top_i,
  input  logic [15:0]    rect_right_i,
  input  logic [15:0]    rect_bottom_i,
  input  logic [7:0]     pixel_value_i,
  output logic           cmd_valid_o,
  output tnns_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);

  tnns_pkg::cmd_t q_q [2];
  tnns_pkg::cmd_t in_cmd;
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;
  logic           accept;
  logic           keep;

  // classify the request, unused opcodes never enter the queue
  always_comb begin
    in_cmd.op     = tnns_pkg::op_e'(operation_i);
    in_cmd.left   = rect_left_i;
    in_cmd.top    = rect_top_i;
    in_cmd.right  = rect_right_i;
    in_cmd.bottom = rect_bottom_i;
    in_cmd.pixel  = pixel_value_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign accept      = push_i && !full_o;
  assign keep        = accept && (in_cmd.op != tnns_pkg::OP_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];

  // two-entry command queue storage
  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_q[wr_q] <= in_cmd;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (keep) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
      unique case ({keep, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tnns_back.sv
`default_nettype none

module tnns_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  tnns_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  tnns_pkg::cfg_t cfg_i,
  input  logic           res_pop_i,
  output logic           res_empty_o,
  output tnns_pkg::res_t res_o
);

  localparam int unsigned SW = tnns_pkg::SIDE_W;
  localparam logic [16:0] SIDE_17 = 17'(tnns_pkg::TILE_SIDE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_TICK0,
    ST_TICK1
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOAD,
    PH_DRAIN
  } phase_e;

  state_e  state_q;
  phase_e  phase_q;
  logic [2:0]  step_q;
  logic        start_q;
  logic [15:0] left_q, top_q;
  logic [16:0] rp1_q, bp1_q;
  logic [31:0] prod_q;
  logic [31:0] ox_q, oy_q, ow_q, oh_q;
  logic [SW-1:0] sw_q, sh_q, qx_q, qy_q, rx_q, ry_q, sx_q, sy_q;
  logic [tnns_pkg::COUNT_W-1:0] total_q, load_cnt_q;
  logic [31:0] px_q, py_q, ax_q, ay_q;
  logic [47:0] row_q;
  logic [31:0] tx_q, ty_q;
  logic        last_q;

  tnns_pkg::res_t oq_q [2];
  logic           owr_q, ord_q;
  logic [1:0]     ocnt_q;

  tnns_pkg::div_req_t div_req;
  tnns_pkg::div_rsp_t div_rsp;

  logic [15:0] den_eff;
  logic [16:0] mul_in;
  logic [32:0] mul_full;
  logic [16:0] width_full, height_full;
  logic [32:0] sum_x, sum_y;
  logic        wrap_x, wrap_y;
  logic [31:0] ax_n, ay_n;
  logic [SW-1:0] sx_n, sy_n;
  logic [2*SW-1:0] idx_full;
  logic [2*SW-1:0] total_full;
  logic [31:0] tx_c, ty_c;
  logic        last_c;
  logic [48:0] addr_full;
  logic        enable_c;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;
  logic        res_push;

  // tile setup arithmetic, one product for each of the first four division steps
  assign den_eff = (cfg_i.denominator == 16'd0) ? 16'd1 : cfg_i.denominator;

  always_comb begin
    unique case (step_q)
      3'd0:    mul_in = {1'b0, left_q};
      3'd1:    mul_in = {1'b0, top_q};
      3'd2:    mul_in = rp1_q;
      default: mul_in = bp1_q;
    endcase
  end

  assign mul_full = 33'(cfg_i.numerator) * 33'(mul_in);

  assign width_full  = {1'b0, cmd_i.right} - {1'b0, cmd_i.left} + 17'd1;
  assign height_full = {1'b0, cmd_i.bottom} - {1'b0, cmd_i.top} + 17'd1;

  always_comb begin
    div_req.start    = start_q;
    div_req.dividend = prod_q;
    if (step_q < 3'd4) begin
      div_req.divisor = {16'd0, den_eff};
    end else if (step_q == 3'd4) begin
      div_req.divisor = ow_q;
    end else begin
      div_req.divisor = oh_q;
    end
  end

  tnns_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // incremental source stepping per axis
  assign sum_x  = {1'b0, ax_q} + 33'(rx_q);
  assign sum_y  = {1'b0, ay_q} + 33'(ry_q);
  assign wrap_x = (sum_x >= {1'b0, ow_q});
  assign wrap_y = (sum_y >= {1'b0, oh_q});
  assign ax_n   = wrap_x ? 32'(sum_x - {1'b0, ow_q}) : sum_x[31:0];
  assign ay_n   = wrap_y ? 32'(sum_y - {1'b0, oh_q}) : sum_y[31:0];
  assign sx_n   = sx_q + qx_q + SW'(wrap_x);
  assign sy_n   = sy_q + qy_q + SW'(wrap_y);

  assign idx_full   = (2*SW)'(sy_q) * (2*SW)'(sw_q) + (2*SW)'(sx_q);
  assign total_full = (2*SW)'(sw_q) * (2*SW)'(sh_q);
  assign tx_c       = ox_q + px_q;
  assign ty_c       = oy_q + py_q;
  assign last_c     = (px_q + 32'd1 == ow_q) && (py_q + 32'd1 == oh_q);

  // tile pixel store
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && (ocnt_q != 2'd2);
  assign ram_we    = cmd_pop_o && (cmd_i.op == tnns_pkg::OP_LOAD) && (phase_q == PH_LOAD);
  assign ram_re    = (state_q == ST_TICK0);

  tnns_ram #(
    .Width(8),
    .Depth(tnns_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(load_cnt_q[tnns_pkg::STORE_AW-1:0]),
    .wdata_i(cmd_i.pixel),
    .re_i   (ram_re),
    .raddr_i(idx_full[tnns_pkg::STORE_AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // frame address and bounds
  assign addr_full = {1'b0, row_q} + 49'(tx_q);
  assign enable_c  = (tx_q < {16'd0, cfg_i.frame_width}) &&
                     (ty_q < {16'd0, cfg_i.frame_height}) &&
                     (addr_full < {17'd0, cfg_i.frame_length});
  assign res_push  = (state_q == ST_TICK1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_IDLE;
      step_q     <= '0;
      start_q    <= 1'b0;
      left_q     <= '0;
      top_q      <= '0;
      rp1_q      <= '0;
      bp1_q      <= '0;
      prod_q     <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      ow_q       <= '0;
      oh_q       <= '0;
      sw_q       <= '0;
      sh_q       <= '0;
      qx_q       <= '0;
      qy_q       <= '0;
      rx_q       <= '0;
      ry_q       <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      total_q    <= '0;
      load_cnt_q <= '0;
      px_q       <= '0;
      py_q       <= '0;
      ax_q       <= '0;
      ay_q       <= '0;
      row_q      <= '0;
      tx_q       <= '0;
      ty_q       <= '0;
      last_q     <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.op)
              tnns_pkg::OP_BEGIN: begin
                phase_q <= PH_IDLE;
                left_q  <= cmd_i.left;
                top_q   <= cmd_i.top;
                rp1_q   <= {1'b0, cmd_i.right} + 17'd1;
                bp1_q   <= {1'b0, cmd_i.bottom} + 17'd1;
                sw_q    <= (width_full > SIDE_17) ? SW'(tnns_pkg::TILE_SIDE)
                                                  : width_full[SW-1:0];
                sh_q    <= (height_full > SIDE_17) ? SW'(tnns_pkg::TILE_SIDE)
                                                   : height_full[SW-1:0];
                step_q  <= '0;
                if (cmd_i.right >= cmd_i.left && cmd_i.bottom >= cmd_i.top) begin
                  state_q <= ST_MUL;
                end
              end
              tnns_pkg::OP_LOAD: begin
                if (phase_q == PH_LOAD) begin
                  load_cnt_q <= load_cnt_q + 1'b1;
                  if (load_cnt_q + 1'b1 >= total_q) begin
                    phase_q <= PH_DRAIN;
                  end
                end
              end
              tnns_pkg::OP_TICK: begin
                if (phase_q == PH_DRAIN) begin
                  state_q <= ST_TICK0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          if (step_q < 3'd4) begin
            prod_q <= mul_full[31:0];
          end else if (step_q == 3'd4) begin
            prod_q <= 32'(sw_q);
          end else begin
            prod_q <= 32'(sh_q);
          end
          start_q <= 1'b1;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            step_q  <= step_q + 3'd1;
            state_q <= ST_MUL;
            unique case (step_q)
              3'd0: ox_q <= div_rsp.quotient;
              3'd1: oy_q <= div_rsp.quotient;
              3'd2: ow_q <= div_rsp.quotient - ox_q;
              3'd3: begin
                oh_q    <= div_rsp.quotient - oy_q;
                state_q <= ST_CHECK;
              end
              3'd4: begin
                qx_q <= div_rsp.quotient[SW-1:0];
                rx_q <= div_rsp.remainder[SW-1:0];
              end
              default: begin
                qy_q       <= div_rsp.quotient[SW-1:0];
                ry_q       <= div_rsp.remainder[SW-1:0];
                total_q    <= total_full[tnns_pkg::COUNT_W-1:0];
                load_cnt_q <= '0;
                px_q       <= '0;
                py_q       <= '0;
                sx_q       <= '0;
                sy_q       <= '0;
                ax_q       <= '0;
                ay_q       <= '0;
                phase_q    <= PH_LOAD;
                state_q    <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CHECK: begin
          // an empty scaled tile is dropped
          if (ow_q == 32'd0 || oh_q == 32'd0) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_TICK0: begin
          row_q   <= 48'(ty_c) * 48'(cfg_i.frame_width);
          tx_q    <= tx_c;
          ty_q    <= ty_c;
          last_q  <= last_c;
          state_q <= ST_TICK1;
          if (last_c) begin
            phase_q <= PH_IDLE;
          end else if (px_q + 32'd1 == ow_q) begin
            px_q <= '0;
            sx_q <= '0;
            ax_q <= '0;
            py_q <= py_q + 32'd1;
            sy_q <= sy_n;
            ay_q <= ay_n;
          end else begin
            px_q <= px_q + 32'd1;
            sx_q <= sx_n;
            ax_q <= ax_n;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[owr_q].address <= addr_full[31:0];
      oq_q[owr_q].value   <= ram_rdata;
      oq_q[owr_q].enable  <= enable_c;
      oq_q[owr_q].last    <= last_q;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        owr_q <= ~owr_q;
      end
      if (res_pop_i) begin
        ord_q <= ~ord_q;
      end
      unique case ({res_push, res_pop_i})
        2'b10:   ocnt_q <= ocnt_q + 2'd1;
        2'b01:   ocnt_q <= ocnt_q - 2'd1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  assign res_empty_o = (ocnt_q == 2'd0);
  assign res_o       = oq_q[ord_q];

endmodule

`default_nettype wire

FILE: rtl/core/tnns_checker.sv
`default_nettype none

module tnns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] write_address_o,
  input logic [7:0]  write_value_o,
  input logic        write_enable_o,
  input logic        last_of_tile_o
);

  // reset leaves no result waiting
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for requests
  assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("request queue full after reset");

  // results only drain through pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result vanished without pop");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(write_address_o) &&
      $stable(write_value_o) && $stable(write_enable_o) && $stable(last_of_tile_o)))
    else $error("waiting result changed");

endmodule

bind tile_nearest_neighbor_scaler_core tnns_checker u_checker (.*);

`default_nettype wire

FILE: tb/tnns_write_checker.sv
`default_nettype none

module tnns_write_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  operation_i,
  input  logic [15:0] rect_left_i,
  input  logic [15:0] rect_top_i,
  input  logic [15:0] rect_right_i,
  input  logic [15:0] rect_bottom_i,
  input  logic [7:0]  pixel_value_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] write_address_o,
  input  logic [7:0]  write_value_o,
  input  logic        write_enable_o,
  input  logic        last_of_tile_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_LOADING, PH_DRAINING} phase_e;

  // shadow registers and tile state
  tnns_pkg::cfg_t regs;
  logic [7:0]     tile_pixels [tnns_pkg::STORE_DEPTH];
  int unsigned    loaded;
  int unsigned    src_w, src_h;
  logic [31:0]    org_x, org_y, tgt_w, tgt_h;
  logic [31:0]    pos_x, pos_y;
  phase_e         phase;
  tnns_pkg::res_t pending_writes [$];
  int             errors;

  assign error_count_o = errors;
  assign pending_o     = pending_writes.size();

  function automatic logic [31:0] nearest_source(logic [31:0] offs, int unsigned src,
                                                 logic [31:0] tgt);
    longint unsigned s;
    s = (longint'(offs) * longint'(src)) / longint'(tgt);
    if (s >= src) s = src - 1;
    return s[31:0];
  endfunction

  // begin: work out target rectangle from the ratio
  task automatic open_tile(logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b);
    longint unsigned n, d, ox, oy, ow, oh;
    n = regs.numerator;
    d = (regs.denominator == 0) ? 1 : regs.denominator;
    phase = PH_IDLE;
    if (r < l || b < t) return;
    ox = n * l / d;
    oy = n * t / d;
    ow = n * (longint'(r) + 1) / d - ox;
    oh = n * (longint'(b) + 1) / d - oy;
    if (ow == 0 || oh == 0) return;
    org_x = ox[31:0];
    org_y = oy[31:0];
    tgt_w = ow[31:0];
    tgt_h = oh[31:0];
    src_w = (r - l + 1 > tnns_pkg::TILE_SIDE) ? tnns_pkg::TILE_SIDE : r - l + 1;
    src_h = (b - t + 1 > tnns_pkg::TILE_SIDE) ? tnns_pkg::TILE_SIDE : b - t + 1;
    loaded = 0;
    pos_x = 0;
    pos_y = 0;
    phase = PH_LOADING;
  endtask

  // tick: one frame write from the current target offset
  task automatic emit_write();
    logic [31:0]     sx, sy;
    int unsigned     idx;
    longint unsigned tx, ty, addr;
    tnns_pkg::res_t  w;
    sx = nearest_source(pos_x, src_w, tgt_w);
    sy = nearest_source(pos_y, src_h, tgt_h);
    idx = sy * src_w + sx;
    tx = longint'(org_x) + pos_x;
    ty = longint'(org_y) + pos_y;
    addr = ty * regs.frame_width + tx;
    w.address = addr[31:0];
    w.value   = (idx < tnns_pkg::STORE_DEPTH) ? tile_pixels[idx] : 8'd0;
    w.enable  = (tx < regs.frame_width) && (ty < regs.frame_height) &&
                (addr < regs.frame_length);
    w.last    = (pos_x + 1 == tgt_w) && (pos_y + 1 == tgt_h);
    pending_writes.push_back(w);
    if (w.last) begin
      phase = PH_IDLE;
    end else if (pos_x + 1 == tgt_w) begin
      pos_x = 0;
      pos_y = pos_y + 1;
    end else begin
      pos_x = pos_x + 1;
    end
  endtask

  // watch the request, config and result channels
  always @(posedge clk_i or negedge rst_ni) begin
    tnns_pkg::res_t got, exp_w;
    if (!rst_ni) begin
      regs = '{numerator: 16'd1, denominator: 16'd1, frame_width: 16'd1,
               frame_height: 16'd1, frame_length: 32'd0};
      loaded = 0;
      src_w = 0;
      src_h = 0;
      org_x = 0;
      org_y = 0;
      tgt_w = 0;
      tgt_h = 0;
      pos_x = 0;
      pos_y = 0;
      phase = PH_IDLE;
      pending_writes.delete();
      errors = 0;
    end else begin
      // result side
      if (pop && !empty) begin
        got = '{address: write_address_o, value: write_value_o,
                enable: write_enable_o, last: last_of_tile_o};
        if (pending_writes.size() == 0) begin
          errors++;
          $display("%0t: unexpected write: expected none, actual %h", $time, got);
        end else begin
          exp_w = pending_writes.pop_front();
          if (got.address !== exp_w.address) begin
            errors++;
            $display("%0t: write_address expected %h actual %h", $time,
                     exp_w.address, got.address);
          end
          if (got.value !== exp_w.value) begin
            errors++;
            $display("%0t: write_value expected %h actual %h", $time,
                     exp_w.value, got.value);
          end
          if (got.enable !== exp_w.enable) begin
            errors++;
            $display("%0t: write_enable expected %b actual %b", $time,
                     exp_w.enable, got.enable);
          end
          if (got.last !== exp_w.last) begin
            errors++;
            $display("%0t: last_of_tile expected %b actual %b", $time,
                     exp_w.last, got.last);
          end
        end
      end
      // config side
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tnns_pkg::REG_NUMERATOR:    regs.numerator    = cfg_data_i[15:0];
          tnns_pkg::REG_DENOMINATOR:  regs.denominator  = cfg_data_i[15:0];
          tnns_pkg::REG_FRAME_WIDTH:  regs.frame_width  = cfg_data_i[15:0];
          tnns_pkg::REG_FRAME_HEIGHT: regs.frame_height = cfg_data_i[15:0];
          tnns_pkg::REG_FRAME_LENGTH: regs.frame_length = cfg_data_i;
          default: ;
        endcase
      end
      // request side
      if (push && !full) begin
        case (tnns_pkg::op_e'(operation_i))
          tnns_pkg::OP_BEGIN: open_tile(rect_left_i, rect_top_i, rect_right_i, rect_bottom_i);
          tnns_pkg::OP_LOAD: begin
            if (phase == PH_LOADING) begin
              if (loaded < tnns_pkg::STORE_DEPTH) tile_pixels[loaded] = pixel_value_i;
              loaded++;
              if (loaded >= src_w * src_h) phase = PH_DRAINING;
            end
          end
          tnns_pkg::OP_TICK: begin
            if (phase == PH_DRAINING) emit_write();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;

  localparam int SETTLE_CYCLES = 1000;
  localparam int STALL_LIMIT   = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = tnns_pkg::OP_NONE;
  logic [15:0] rect_left_i = '0, rect_top_i = '0, rect_right_i = '0, rect_bottom_i = '0;
  logic [7:0]  pixel_value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] write_address_o;
  logic [7:0]  write_value_o;
  logic        write_enable_o, last_of_tile_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          error_count, pending;
  int          items_sent;
  bit          pop_steady;
  int          pop_hold;
  int          quiet_cycles;
  logic [15:0] cur_num, cur_den;

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tile_nearest_neighbor_scaler_core dut (.*);

  tnns_write_checker u_checker (
    .*, .error_count_o(error_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // result side stalls, with stretches of steady popping
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) pop_steady <= !pop_steady;
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else begin
        pop <= 1'b1;
        if (!pop_steady && $urandom_range(0, 5) == 0) pop_hold <= gap_len();
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(tnns_pkg::op_e op, logic [15:0] l, logic [15:0] t,
                              logic [15:0] r, logic [15:0] b, logic [7:0] pix);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push          <= 1'b1;
    operation_i   <= op;
    rect_left_i   <= l;
    rect_top_i    <= t;
    rect_right_i  <= r;
    rect_bottom_i <= b;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // wait for all writes, let begins and loads settle
  task automatic drain_all();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tnns_pkg::REG_NUMERATOR) cur_num = data[15:0];
    if (idx == tnns_pkg::REG_DENOMINATOR) cur_den = data[15:0];
  endtask

  task automatic set_frame(logic [15:0] n, logic [15:0] d, logic [15:0] fw, logic [15:0] fh,
                           logic [31:0] len);
    drain_all();
    write_reg(tnns_pkg::REG_NUMERATOR, {16'h0, n});
    write_reg(tnns_pkg::REG_DENOMINATOR, {16'h0, d});
    write_reg(tnns_pkg::REG_FRAME_WIDTH, {16'h0, fw});
    write_reg(tnns_pkg::REG_FRAME_HEIGHT, {16'h0, fh});
    write_reg(tnns_pkg::REG_FRAME_LENGTH, len);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic longint unsigned extent(logic [15:0] lo, logic [15:0] hi);
    longint unsigned d;
    d = (cur_den == 0) ? 1 : cur_den;
    return longint'(cur_num) * (longint'(hi) + 1) / d - longint'(cur_num) * lo / d;
  endfunction

  // one tile: begin, loads, ticks, with abandoned and noisy variants
  task automatic run_tile(int w, int h, bit wide_coords);
    logic [15:0]     l, t, r, b;
    int              loads, ticks, span;
    longint unsigned area;
    span = wide_coords ? 65535 : 40;
    l = 16'($urandom_range(0, span - w + 1));
    t = 16'($urandom_range(0, span - h + 1));
    r = 16'(l + w - 1);
    b = 16'(t + h - 1);
    if ($urandom_range(0, 19) == 0) begin
      send_request(tnns_pkg::OP_BEGIN, r, b, 16'(l - 1), 16'(t - 1), 8'($urandom));
      r = 16'(l - 1);
    end else begin
      send_request(tnns_pkg::OP_BEGIN, l, t, r, b, 8'($urandom));
    end
    loads = ((w > tnns_pkg::TILE_SIDE) ? tnns_pkg::TILE_SIDE : w) *
            ((h > tnns_pkg::TILE_SIDE) ? tnns_pkg::TILE_SIDE : h);
    if ($urandom_range(0, 9) == 0) loads = int'($urandom_range(0, loads));
    repeat (loads) send_request(tnns_pkg::OP_LOAD, 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 8'($urandom));
    area = (r < l) ? 0 : extent(l, r) * extent(t, b);
    ticks = (area > 40) ? 40 : int'(area) + int'($urandom_range(0, 2));
    repeat (ticks) send_request(tnns_pkg::OP_TICK, 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 8'($urandom));
    if ($urandom_range(0, 7) == 0)
      send_request($urandom_range(0, 1) ? tnns_pkg::OP_NONE : tnns_pkg::OP_LOAD,
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom));
  endtask

  initial begin
    int w, h, sel;
    items_sent = 0;
    pop_steady = 1'b0;
    pop_hold = 0;
    quiet_cycles = 0;
    cur_num = 16'd1;
    cur_den = 16'd1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle noise, reversed rect, 2x2 extremes, abandoned tile, far corner
    set_frame(16'd1, 16'd1, 16'd64, 16'd64, 32'd4096);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'hFF);
    send_request(tnns_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    send_request(tnns_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(tnns_pkg::OP_BEGIN, 16'd5, 16'd5, 16'd4, 16'd6, 8'h00);
    send_request(tnns_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    send_request(tnns_pkg::OP_BEGIN, 16'd0, 16'd0, 16'd1, 16'd1, 8'h00);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'hFF);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'hA5);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'h5A);
    repeat (5) send_request(tnns_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    send_request(tnns_pkg::OP_BEGIN, 16'd3, 16'd3, 16'd5, 16'd5, 8'h00);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'h11);
    send_request(tnns_pkg::OP_BEGIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'h77);
    send_request(tnns_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    // empty scaled tile at half ratio, zero denominator acting as one
    set_frame(16'd1, 16'd2, 16'd64, 16'd64, 32'd4096);
    send_request(tnns_pkg::OP_BEGIN, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
    send_request(tnns_pkg::OP_LOAD, 16'h0, 16'h0, 16'h0, 16'h0, 8'h33);
    send_request(tnns_pkg::OP_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00);
    set_frame(16'd2, 16'd0, 16'd64, 16'd64, 32'd4096);
    run_tile(2, 1, 1'b0);

    // random phases over ratio and frame settings
    while (items_sent < 720) begin
      sel = int'($urandom_range(0, 9));
      case (sel)
        0: set_frame(16'd1, 16'd1, 16'd64, 16'd64, 32'd4096);
        1: set_frame(16'd2, 16'd1, 16'd65535, 16'd65535, 32'hFFFFFFFF);
        2: set_frame(16'd1, 16'd2, 16'd1, 16'd1, 32'd0);
        3: set_frame(16'd3, 16'd2, 16'd48, 16'd40, 32'($urandom_range(0, 3000)));
        4: set_frame(16'd2, 16'd3, 16'd64, 16'd64, 32'd4096);
        5: set_frame(16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom), 32'($urandom));
        6: set_frame(16'd1, 16'hFFFF, 16'd64, 16'd64, 32'd4096);
        7: set_frame(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 32'hFFFFFFFF);
        8: set_frame(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                     16'($urandom_range(1, 80)), 16'($urandom_range(1, 80)),
                     32'($urandom_range(0, 6400)));
        default: set_frame(16'd1, 16'd1, 16'd40, 16'd40, 32'd1600);
      endcase
      repeat (6) begin
        sel = int'($urandom_range(0, 99));
        if (sel < 80) begin
          w = int'($urandom_range(1, 4));
          h = int'($urandom_range(1, 4));
        end else if (sel < 95) begin
          w = int'($urandom_range(5, 8));
          h = int'($urandom_range(1, 3));
        end else begin
          w = int'($urandom_range(17, 19));
          h = int'($urandom_range(1, 2));
        end
        run_tile(w, h, $urandom_range(0, 9) < 3);
      end
    end

    drain_all();
    if (error_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
